// ===== hw/rtl/sc1a_pkg.sv =====
// Shared types, key numbers and translation tables for the set-1 scancode translator.
// No dependencies; imported by the decoder and the top level.
`default_nettype none

package sc1a_pkg;

   // Modifier keys that are held down
   typedef struct packed {
      logic alt;
      logic ctrl;
      logic shift;
   } sc1a_held_type;

   // Decoder outcome for one scancode word
   typedef struct packed {
      logic          hit;
      logic [7:0]    keycode;
      sc1a_held_type held_next;
   } sc1a_dec_type;

   // Key numbers of the modifier keys (bits 6..0 of a scancode)
   localparam logic [6:0] KEY_CTRL   = 7'h1D;
   localparam logic [6:0] KEY_LSHIFT = 7'h2A;
   localparam logic [6:0] KEY_RSHIFT = 7'h36;
   localparam logic [6:0] KEY_ALT    = 7'h38;

   // Character bounds used by the Ctrl mapping and the shift table
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Plain table; keys past the end of the table and blank keys read zero
   function automatic logic [7:0] plain_entry(input logic [6:0] key);
      logic [7:0] val;
      case (key)
         7'd1:  val = 8'h1B;
         7'd2:  val = 8'h31;
         7'd3:  val = 8'h32;
         7'd4:  val = 8'h33;
         7'd5:  val = 8'h34;
         7'd6:  val = 8'h35;
         7'd7:  val = 8'h36;
         7'd8:  val = 8'h37;
         7'd9:  val = 8'h38;
         7'd10: val = 8'h39;
         7'd11: val = 8'h30;
         7'd12: val = 8'h2D;
         7'd13: val = 8'h3D;
         7'd14: val = 8'h08;
         7'd15: val = 8'h09;
         7'd16: val = 8'h71;
         7'd17: val = 8'h77;
         7'd18: val = 8'h65;
         7'd19: val = 8'h72;
         7'd20: val = 8'h74;
         7'd21: val = 8'h79;
         7'd22: val = 8'h75;
         7'd23: val = 8'h69;
         7'd24: val = 8'h6F;
         7'd25: val = 8'h70;
         7'd26: val = 8'h5B;
         7'd27: val = 8'h5D;
         7'd28: val = 8'h0A;
         7'd30: val = 8'h61;
         7'd31: val = 8'h73;
         7'd32: val = 8'h64;
         7'd33: val = 8'h66;
         7'd34: val = 8'h67;
         7'd35: val = 8'h68;
         7'd36: val = 8'h6A;
         7'd37: val = 8'h6B;
         7'd38: val = 8'h6C;
         7'd39: val = 8'h3B;
         7'd40: val = 8'h27;
         7'd41: val = 8'h60;
         7'd43: val = 8'h5C;
         7'd44: val = 8'h7A;
         7'd45: val = 8'h78;
         7'd46: val = 8'h63;
         7'd47: val = 8'h76;
         7'd48: val = 8'h62;
         7'd49: val = 8'h6E;
         7'd50: val = 8'h6D;
         7'd51: val = 8'h2C;
         7'd52: val = 8'h2E;
         7'd53: val = 8'h2F;
         7'd57: val = 8'h20;
         // F1..F10
         7'd59: val = 8'h80;
         7'd60: val = 8'h81;
         7'd61: val = 8'h82;
         7'd62: val = 8'h83;
         7'd63: val = 8'h84;
         7'd64: val = 8'h85;
         7'd65: val = 8'h86;
         7'd66: val = 8'h87;
         7'd67: val = 8'h88;
         7'd68: val = 8'h89;
         // keypad / cursor block
         7'd71: val = 8'h92;
         7'd72: val = 8'h97;
         7'd73: val = 8'h94;
         7'd74: val = 8'h2D;
         7'd75: val = 8'h96;
         7'd76: val = 8'h35;
         7'd77: val = 8'h99;
         7'd78: val = 8'h2B;
         7'd79: val = 8'h93;
         7'd80: val = 8'h98;
         7'd81: val = 8'h95;
         7'd82: val = 8'h90;
         7'd83: val = 8'h91;
         // F11, F12
         7'd87: val = 8'h8A;
         7'd88: val = 8'h8B;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // Shift table: symbols differ, letters go upper case, the rest matches plain
   function automatic logic [7:0] shift_entry(input logic [6:0] key);
      logic [7:0] base;
      logic [7:0] val;
      base = plain_entry(key);
      case (key)
         7'd2:  val = 8'h21;
         7'd3:  val = 8'h40;
         7'd4:  val = 8'h23;
         7'd5:  val = 8'h24;
         7'd6:  val = 8'h25;
         7'd7:  val = 8'h5E;
         7'd8:  val = 8'h26;
         7'd9:  val = 8'h2A;
         7'd10: val = 8'h28;
         7'd11: val = 8'h29;
         7'd12: val = 8'h5F;
         7'd13: val = 8'h2B;
         7'd26: val = 8'h7B;
         7'd27: val = 8'h7D;
         7'd39: val = 8'h3A;
         7'd40: val = 8'h22;
         7'd41: val = 8'h7E;
         7'd43: val = 8'h7C;
         7'd51: val = 8'h3C;
         7'd52: val = 8'h3E;
         7'd53: val = 8'h3F;
         default: begin
            if (base >= CHAR_LOWER_A && base <= CHAR_LOWER_Z) begin
               val = base - CASE_OFFSET;
            end else begin
               val = base;
            end
         end
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sc1a_req_if.sv =====
// Scancode input channel: valid/ready handshake carrying one scancode word.
// No dependencies.
`default_nettype none

interface sc1a_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scancode;

   modport source (output valid, output scancode, input ready);
   modport sink   (input valid, input scancode, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sc1a_rsp_if.sv =====
// Key code result channel: valid/ready handshake carrying one key code word.
// No dependencies.
`default_nettype none

interface sc1a_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] keycode;

   modport source (output valid, output keycode, input ready);
   modport sink   (input valid, input keycode, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scancode_set1_to_ascii.sv =====
// Top level of the set-1 scancode to key code translator: input register,
// decoder, modifier state and result register. Depends on sc1a_pkg, sc1a_req_if,
// sc1a_rsp_if and sc1a_decode.
//
//   channel  | dir | payload        | handshake
//   ---------+-----+----------------+------------------
//   req_port | in  | scancode [7:0] | valid && ready
//   rsp_port | out | keycode  [7:0] | valid && ready
//
// One scancode word per cycle is accepted unless a stalled result register holds the input
// register; a result goes from the input register through the decoder into the result register.
// Words that give no result (releases, modifier presses, blank keys) retire from
// the input register without touching the result register.
// Reset clears the held Alt/Ctrl/Shift bits and both valid flags.
// A stalled result register holds the input register only for a word that gives
// a result; the input side keeps taking words as long as that register frees up.
`default_nettype none

module scancode_set1_to_ascii (
   input wire logic clock,
   input wire logic reset,
   sc1a_req_if.sink   req_port,
   sc1a_rsp_if.source rsp_port
);
   import sc1a_pkg::*;

   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic [7:0]    s1_scancode_ff;
   sc1a_held_type held_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [7:0]    rsp_keycode_ff;
   sc1a_dec_type  dec;
   logic          out_free;
   logic          s1_retire;
   logic          req_take;

   sc1a_decode u_decode (
      .scancode (s1_scancode_ff),
      .held     (held_ff),
      .dec      (dec)
   );

   // Retire the input word when it gives no result or the result register is free
   assign out_free  = !rsp_valid_ff || rsp_port.ready;
   assign s1_retire = s1_valid_ff && (!dec.hit || out_free);
   assign req_port.ready = !s1_valid_ff || s1_retire;
   assign req_take  = req_port.valid && req_port.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_retire);
   assign rsp_valid_in = (s1_retire && dec.hit) || (rsp_valid_ff && !rsp_port.ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_retire) begin
            held_ff <= dec.held_next;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_scancode_ff <= req_port.scancode;
      end
      if (s1_retire && dec.hit) begin
         rsp_keycode_ff <= dec.keycode;
      end
   end

   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.keycode = rsp_keycode_ff;

`ifndef SYNTH
   // Modifiers come out of reset released
   a_held_reset: assert property (@(posedge clock)
      $past(reset) |-> (held_ff == '0))
      else $error("modifier state not cleared by reset");

   // A word with a result waiting on a stalled output is held, not dropped
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && dec.hit && rsp_valid_ff && !rsp_port.ready)
      |=> (s1_valid_ff && $stable(s1_scancode_ff)))
      else $error("input word lost while result register stalled");

   // Releases never give a result
   a_release_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_scancode_ff[7]) |-> !dec.hit)
      else $error("key release produced a result");

   // With Alt held, every non-modifier press gives a result
   a_alt_passes: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_scancode_ff[7] && held_ff.alt &&
       s1_scancode_ff[6:0] != KEY_ALT && s1_scancode_ff[6:0] != KEY_CTRL &&
       s1_scancode_ff[6:0] != KEY_LSHIFT && s1_scancode_ff[6:0] != KEY_RSHIFT)
      |-> dec.hit)
      else $error("Alt pass-through gave no result");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sc1a_decode.sv =====
// Combinational decoder: one scancode word plus held modifiers to key code and next modifiers.
// Depends on sc1a_pkg.
`default_nettype none

module sc1a_decode (
   input  wire logic [7:0]            scancode,
   input  wire sc1a_pkg::sc1a_held_type held,
   output sc1a_pkg::sc1a_dec_type     dec
);
   import sc1a_pkg::*;

   logic [6:0] key;
   logic       release_key;
   logic       is_alt;
   logic       is_ctrl;
   logic       is_shift;
   logic [7:0] plain_val;
   logic [7:0] shift_val;

   assign key         = scancode[6:0];
   assign release_key = scancode[7];
   assign is_alt      = (key == KEY_ALT);
   assign is_ctrl     = (key == KEY_CTRL);
   assign is_shift    = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);
   assign plain_val   = plain_entry(key);
   assign shift_val   = shift_entry(key);

   always_comb begin
      dec.hit       = 1'b0;
      dec.keycode   = 8'h00;
      dec.held_next = held;
      if (release_key) begin
         // releases only ever clear a modifier
         if (is_alt) begin
            dec.held_next.alt = 1'b0;
         end else if (is_ctrl) begin
            dec.held_next.ctrl = 1'b0;
         end else if (is_shift) begin
            dec.held_next.shift = 1'b0;
         end
      end else if (is_alt) begin
         dec.held_next.alt = 1'b1;
      end else if (is_ctrl) begin
         dec.held_next.ctrl = 1'b1;
      end else if (is_shift) begin
         dec.held_next.shift = 1'b1;
      end else if (held.alt) begin
         // raw key number, any key
         dec.hit     = 1'b1;
         dec.keycode = {1'b0, key};
      end else if (held.ctrl) begin
         // a..z and [..._ both reduce to their low five bits
         if ((plain_val >= CHAR_LOWER_A && plain_val <= CHAR_LOWER_Z) ||
             (plain_val >= CHAR_LBRACKET && plain_val <= CHAR_UNDERSCORE)) begin
            dec.hit     = 1'b1;
            dec.keycode = {3'b000, plain_val[4:0]};
         end
      end else if (held.shift) begin
         dec.hit     = (shift_val != 8'h00);
         dec.keycode = shift_val;
      end else begin
         dec.hit     = (plain_val != 8'h00);
         dec.keycode = plain_val;
      end
   end

endmodule

`default_nettype wire
